>>> rtl/core/particle_tick_integrator_macros.svh
// Assertion helpers shared by the integrator RTL.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef PARTICLE_TICK_INTEGRATOR_MACROS_SVH
`define PARTICLE_TICK_INTEGRATOR_MACROS_SVH

// Same-cycle implication
`define PTI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PTI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pti_pkg.sv
package pti_pkg;

    // Field widths
    localparam int DT_W      = 16;
    localparam int AGE_W     = 25;
    localparam int LIFE_W    = 24;
    localparam int VEC_W     = 16;
    localparam int VEC3_W    = 48;
    localparam int POS_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int N_AXES    = 3;
    localparam int N_CHAN    = 4;
    localparam int IDX_W     = 2;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    // (dir + g) * speed fits this many signed bits
    localparam int DV_PROD_W = 34;

    // Floor shifts of the products
    localparam int GRAV_SHIFT = 16;
    localparam int POS_SHIFT  = 26;

    // Colour divider: |step| * dt < 2^31
    localparam int DIV_W     = 31;
    localparam int DIV_CNT_W = 5;

    // Width of the saturating sums
    localparam int SUM_W = POS_W + 1;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    localparam logic signed [SUM_W-1:0] VEC_HI = 33'sd32767;
    localparam logic signed [SUM_W-1:0] VEC_LO = -33'sd32768;
    localparam logic signed [SUM_W-1:0] POS_HI = 33'sd2147483647;
    localparam logic signed [SUM_W-1:0] POS_LO = -33'sd2147483648;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_ACCEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LIFE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS  = 3'd7;

    // Multiplier operand selects
    localparam logic [1:0] MUL_SEL_COLOR = 2'd0;
    localparam logic [1:0] MUL_SEL_ACCEL = 2'd1;
    localparam logic [1:0] MUL_SEL_DIRV  = 2'd2;
    localparam logic [1:0] MUL_SEL_DT    = 2'd3;

    typedef struct packed {
        logic             take_item;
        logic [1:0]       mul_sel;
        logic [IDX_W-1:0] idx;
        logic             prod_wr;
        logic             div_start;
        logic             grav_wr;
        logic             pos_wr;
        logic             color_wr;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic expired;
        logic div_done;
    } stat_t;

endpackage

>>> rtl/core/pti_div_lane.sv
// Radix-2 restoring divider, one quotient bit per cycle
module pti_div_lane
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pti_pkg::DIV_W-1:0]         dividend,
    input  logic [pti_pkg::LIFE_W-1:0]        divisor,
    output logic [pti_pkg::DIV_W-1:0]         quotient,
    output logic                              rem_nz,
    output logic                              done
);

    logic [pti_pkg::DIV_W-1:0]     quo_reg;
    logic [pti_pkg::LIFE_W-1:0]    rem_reg;
    logic [pti_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [pti_pkg::LIFE_W:0]      trial;
    logic [pti_pkg::LIFE_W:0]      diff;
    logic                          fits;

    // Trial subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[pti_pkg::DIV_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = trial >= {1'b0, divisor};
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= pti_pkg::DIV_CNT_W'(pti_pkg::DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[pti_pkg::LIFE_W-1:0] : trial[pti_pkg::LIFE_W-1:0];
            quo_reg <= {quo_reg[pti_pkg::DIV_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign rem_nz   = rem_reg != '0;
    assign done     = cnt_reg == '0;

endmodule

>>> rtl/core/pti_datapath.sv
// Registers, particle state, shared multiplier and colour dividers
module pti_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pti_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pti_pkg::CFG_W-1:0]           cfg_data,
    input  logic [pti_pkg::DT_W-1:0]            time_step,
    input  pti_pkg::cmd_t                       cmd,
    output pti_pkg::stat_t                      stat,
    output logic signed [pti_pkg::POS_W-1:0]    pos_x,
    output logic signed [pti_pkg::POS_W-1:0]    pos_y,
    output logic signed [pti_pkg::POS_W-1:0]    pos_z,
    output logic signed [pti_pkg::VEC_W-1:0]    color_r,
    output logic signed [pti_pkg::VEC_W-1:0]    color_g,
    output logic signed [pti_pkg::VEC_W-1:0]    color_b,
    output logic signed [pti_pkg::VEC_W-1:0]    color_a,
    output logic                                dead
);

    function automatic logic signed [pti_pkg::VEC_W-1:0] vec_lane
    (
        input logic [pti_pkg::VEC3_W-1:0] v,
        input logic [pti_pkg::IDX_W-1:0]  i
    );
        logic signed [pti_pkg::VEC_W-1:0] r;
        unique case (i)
            2'd0:    r = v[15:0];
            2'd1:    r = v[31:16];
            default: r = v[47:32];
        endcase
        return r;
    endfunction

    function automatic logic signed [pti_pkg::VEC_W-1:0] sat16
    (
        input logic signed [pti_pkg::SUM_W-1:0] v
    );
        logic signed [pti_pkg::VEC_W-1:0] r;
        if (v > pti_pkg::VEC_HI)
            r = pti_pkg::VEC_HI[pti_pkg::VEC_W-1:0];
        else if (v < pti_pkg::VEC_LO)
            r = pti_pkg::VEC_LO[pti_pkg::VEC_W-1:0];
        else
            r = v[pti_pkg::VEC_W-1:0];
        return r;
    endfunction

    function automatic logic signed [pti_pkg::POS_W-1:0] sat32
    (
        input logic signed [pti_pkg::SUM_W-1:0] v
    );
        logic signed [pti_pkg::POS_W-1:0] r;
        if (v > pti_pkg::POS_HI)
            r = pti_pkg::POS_HI[pti_pkg::POS_W-1:0];
        else if (v < pti_pkg::POS_LO)
            r = pti_pkg::POS_LO[pti_pkg::POS_W-1:0];
        else
            r = v[pti_pkg::POS_W-1:0];
        return r;
    endfunction

    // Configuration
    logic [pti_pkg::VEC3_W-1:0]          accel_reg;
    logic signed [pti_pkg::VEC_W-1:0]    limit_reg;
    logic [pti_pkg::VEC_W-1:0]           speed_reg;
    logic [pti_pkg::VEC3_W-1:0]          dir_reg;
    logic [pti_pkg::LIFE_W-1:0]          life_reg;
    logic [pti_pkg::CFG_W-1:0]           cstep_reg;

    // Particle state
    logic [pti_pkg::AGE_W-1:0]           age_reg;
    logic                                expired_reg;
    logic signed [pti_pkg::VEC_W-1:0]    gv_reg  [pti_pkg::N_AXES];
    logic signed [pti_pkg::POS_W-1:0]    pos_reg [pti_pkg::N_AXES];
    logic signed [pti_pkg::VEC_W-1:0]    col_reg [pti_pkg::N_CHAN];

    // Work registers
    logic [pti_pkg::DT_W-1:0]            dt_reg;
    logic signed [pti_pkg::MUL_P_W-1:0]  prod_reg;
    logic                                neg_reg [pti_pkg::N_CHAN];

    // Output beat
    logic signed [pti_pkg::POS_W-1:0]    out_pos_reg [pti_pkg::N_AXES];
    logic signed [pti_pkg::VEC_W-1:0]    out_col_reg [pti_pkg::N_CHAN];
    logic                                out_dead_reg;

    logic [pti_pkg::AGE_W:0]             age_sum;
    logic [pti_pkg::AGE_W-1:0]           age_sat;
    logic                                life_hit;

    logic signed [pti_pkg::VEC_W-1:0]    step_lane;
    logic signed [pti_pkg::VEC_W:0]      step_ext;
    logic [pti_pkg::VEC_W:0]             step_mag;
    logic signed [pti_pkg::VEC_W:0]      dirv;
    logic signed [pti_pkg::MUL_B_W-1:0]  dt_op;
    logic signed [pti_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [pti_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [pti_pkg::MUL_P_W-1:0]  mul_p;

    logic signed [pti_pkg::VEC_W+1:0]    gsum;
    logic signed [pti_pkg::VEC_W-1:0]    gsat;
    logic signed [pti_pkg::VEC_W-1:0]    gnew;
    logic signed [pti_pkg::SUM_W-1:0]    psum;
    logic signed [pti_pkg::POS_W-1:0]    pnew;

    logic [pti_pkg::DIV_W-1:0]           lane_q    [pti_pkg::N_CHAN];
    logic                                lane_rnz  [pti_pkg::N_CHAN];
    logic [pti_pkg::N_CHAN-1:0]          lane_done;
    logic signed [pti_pkg::VEC_W-1:0]    cnew      [pti_pkg::N_CHAN];

    // Age update and lifetime check
    always_comb
    begin
        age_sum  = {1'b0, age_reg} + (pti_pkg::AGE_W+1)'(time_step);
        age_sat  = age_sum[pti_pkg::AGE_W] ? pti_pkg::AGE_MAX
                                           : age_sum[pti_pkg::AGE_W-1:0];
        life_hit = age_sat >= pti_pkg::AGE_W'(life_reg);
    end

    // Shared multiplier operand select
    always_comb
    begin
        step_lane = cstep_reg[pti_pkg::VEC_W*cmd.idx +: pti_pkg::VEC_W];
        step_ext  = (pti_pkg::VEC_W+1)'(step_lane);
        step_mag  = step_ext[pti_pkg::VEC_W] ? unsigned'(-step_ext) : unsigned'(step_ext);
        dirv      = (pti_pkg::VEC_W+1)'(vec_lane(dir_reg, cmd.idx))
                  + (pti_pkg::VEC_W+1)'(gv_reg[cmd.idx]);
        dt_op     = pti_pkg::MUL_B_W'(signed'({1'b0, dt_reg}));
        unique case (cmd.mul_sel)
            pti_pkg::MUL_SEL_COLOR:
            begin
                mul_a = pti_pkg::MUL_A_W'(signed'({1'b0, step_mag}));
                mul_b = dt_op;
            end
            pti_pkg::MUL_SEL_ACCEL:
            begin
                mul_a = pti_pkg::MUL_A_W'(vec_lane(accel_reg, cmd.idx));
                mul_b = dt_op;
            end
            pti_pkg::MUL_SEL_DIRV:
            begin
                mul_a = pti_pkg::MUL_A_W'(dirv);
                mul_b = pti_pkg::MUL_B_W'(signed'({1'b0, speed_reg}));
            end
            pti_pkg::MUL_SEL_DT:
            begin
                mul_a = pti_pkg::MUL_A_W'(signed'(prod_reg[pti_pkg::DV_PROD_W-1:0]));
                mul_b = dt_op;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Gravity: floor add, saturate, clamp from above
    always_comb
    begin
        gsum = (pti_pkg::VEC_W+2)'(gv_reg[cmd.idx])
             + (pti_pkg::VEC_W+2)'(prod_reg >>> pti_pkg::GRAV_SHIFT);
        gsat = sat16(pti_pkg::SUM_W'(gsum));
        gnew = (gsat > limit_reg) ? limit_reg : gsat;
    end

    // Position: floor add, saturate
    always_comb
    begin
        psum = pti_pkg::SUM_W'(pos_reg[cmd.idx])
             + pti_pkg::SUM_W'(prod_reg >>> pti_pkg::POS_SHIFT);
        pnew = sat32(psum);
    end

    // Colour lanes: one divider each, floor quotient then saturating add
    for (genvar c = 0; c < pti_pkg::N_CHAN; c++)
    begin : g_chan
        logic                             lane_start;
        logic signed [pti_pkg::SUM_W-1:0] qext;
        logic signed [pti_pkg::SUM_W-1:0] cinc;

        assign lane_start = cmd.div_start && (cmd.idx == pti_pkg::IDX_W'(c));

        pti_div_lane u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (lane_start),
            .dividend (mul_p[pti_pkg::DIV_W-1:0]),
            .divisor  (life_reg),
            .quotient (lane_q[c]),
            .rem_nz   (lane_rnz[c]),
            .done     (lane_done[c])
        );

        always_comb
        begin
            qext    = signed'({2'b00, lane_q[c]})
                    + pti_pkg::SUM_W'(signed'({1'b0, lane_rnz[c] && neg_reg[c]}));
            cinc    = neg_reg[c] ? -qext : qext;
            cnew[c] = sat16(cinc + pti_pkg::SUM_W'(col_reg[c]));
        end
    end

    // Configuration and particle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg   <= '0;
            limit_reg   <= 16'sd32767;
            speed_reg   <= 16'd8192;
            dir_reg     <= '0;
            life_reg    <= 24'd65536;
            cstep_reg   <= '0;
            age_reg     <= '0;
            expired_reg <= 1'b0;
            for (int a = 0; a < pti_pkg::N_AXES; a++)
            begin
                gv_reg[a]  <= '0;
                pos_reg[a] <= '0;
            end
            for (int c = 0; c < pti_pkg::N_CHAN; c++)
            begin
                col_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pti_pkg::REG_GRAV_ACCEL: accel_reg <= cfg_data[pti_pkg::VEC3_W-1:0];
                    pti_pkg::REG_GRAV_LIMIT: limit_reg <= cfg_data[pti_pkg::VEC_W-1:0];
                    pti_pkg::REG_MOVE_SPEED: speed_reg <= cfg_data[pti_pkg::VEC_W-1:0];
                    pti_pkg::REG_DIRECTION:  dir_reg   <= cfg_data[pti_pkg::VEC3_W-1:0];
                    pti_pkg::REG_MAX_LIFE:   life_reg  <= cfg_data[pti_pkg::LIFE_W-1:0];
                    pti_pkg::REG_COLOR_STEP: cstep_reg <= cfg_data;
                    pti_pkg::REG_START_COL:
                    begin
                        for (int c = 0; c < pti_pkg::N_CHAN; c++)
                        begin
                            col_reg[c] <= cfg_data[pti_pkg::VEC_W*c +: pti_pkg::VEC_W];
                        end
                    end
                    pti_pkg::REG_START_POS:
                    begin
                        for (int a = 0; a < pti_pkg::N_AXES; a++)
                        begin
                            pos_reg[a] <= {cfg_data[pti_pkg::VEC_W*a +: pti_pkg::VEC_W],
                                           {pti_pkg::FRAC_W{1'b0}}};
                        end
                    end
                endcase
            end
            if (cmd.take_item)
            begin
                age_reg     <= age_sat;
                expired_reg <= expired_reg || life_hit;
            end
            if (cmd.grav_wr)
            begin
                gv_reg[cmd.idx] <= gnew;
            end
            if (cmd.pos_wr)
            begin
                pos_reg[cmd.idx] <= pnew;
            end
            if (cmd.color_wr)
            begin
                for (int c = 0; c < pti_pkg::N_CHAN; c++)
                begin
                    col_reg[c] <= cnew[c];
                end
            end
        end
    end

    // Work and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            dt_reg <= time_step;
        end
        if (cmd.prod_wr)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.div_start)
        begin
            neg_reg[cmd.idx] <= step_lane[pti_pkg::VEC_W-1];
        end
        if (cmd.load_out)
        begin
            for (int a = 0; a < pti_pkg::N_AXES; a++)
            begin
                out_pos_reg[a] <= pos_reg[a];
            end
            for (int c = 0; c < pti_pkg::N_CHAN; c++)
            begin
                out_col_reg[c] <= col_reg[c];
            end
            out_dead_reg <= expired_reg;
        end
    end

    assign stat.expired  = expired_reg;
    assign stat.div_done = &lane_done;

    assign pos_x   = out_pos_reg[0];
    assign pos_y   = out_pos_reg[1];
    assign pos_z   = out_pos_reg[2];
    assign color_r = out_col_reg[0];
    assign color_g = out_col_reg[1];
    assign color_b = out_col_reg[2];
    assign color_a = out_col_reg[3];
    assign dead    = out_dead_reg;

endmodule

>>> rtl/core/pti_ctrl.sv
// Tick sequencer: colour products, per-axis gravity and position steps, result beat
module pti_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            out_stall,
    output logic            out_valid,
    input  pti_pkg::stat_t  stat,
    output pti_pkg::cmd_t   cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_CMUL  = 4'd2;
    localparam logic [3:0] ST_G1    = 4'd3;
    localparam logic [3:0] ST_G2    = 4'd4;
    localparam logic [3:0] ST_P1    = 4'd5;
    localparam logic [3:0] ST_P2    = 4'd6;
    localparam logic [3:0] ST_P3    = 4'd7;
    localparam logic [3:0] ST_DWAIT = 4'd8;
    localparam logic [3:0] ST_COLOR = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]                  state_reg;
    logic [3:0]                  state_next;
    logic [pti_pkg::IDX_W-1:0]   idx_reg;
    logic [pti_pkg::IDX_W-1:0]   idx_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        cmd.idx    = idx_reg;
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                idx_next   = '0;
                state_next = stat.expired ? ST_DONE : ST_CMUL;
            end
            ST_CMUL:
            begin
                cmd.mul_sel   = pti_pkg::MUL_SEL_COLOR;
                cmd.div_start = 1'b1;
                if (idx_reg == pti_pkg::IDX_W'(pti_pkg::N_CHAN - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_G1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_G1:
            begin
                cmd.mul_sel = pti_pkg::MUL_SEL_ACCEL;
                cmd.prod_wr = 1'b1;
                state_next  = ST_G2;
            end
            ST_G2:
            begin
                cmd.grav_wr = 1'b1;
                state_next  = ST_P1;
            end
            ST_P1:
            begin
                cmd.mul_sel = pti_pkg::MUL_SEL_DIRV;
                cmd.prod_wr = 1'b1;
                state_next  = ST_P2;
            end
            ST_P2:
            begin
                cmd.mul_sel = pti_pkg::MUL_SEL_DT;
                cmd.prod_wr = 1'b1;
                state_next  = ST_P3;
            end
            ST_P3:
            begin
                cmd.pos_wr = 1'b1;
                if (idx_reg == pti_pkg::IDX_W'(pti_pkg::N_AXES - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_DWAIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_G1;
                end
            end
            ST_DWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_COLOR;
                end
            end
            ST_COLOR:
            begin
                cmd.color_wr = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/particle_tick_integrator.sv
// Particle tick integrator: advances one particle by one tick per input beat.
// Input channel (in_valid/in_stall) carries time_step; output channel
// (out_valid/out_stall) returns one beat per tick: position, colour, dead.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// writing a start position or start colour also reloads that state.
// For a live tick the colour dividers set how long the block is busy (one
// quotient bit a cycle); they are started one after another from the single
// shared multiplier, and the gravity and position steps run on that
// multiplier while the dividers work. A dead tick skips the multiplier and
// divider steps and goes straight to its result beat.
// One tick is worked at a time; the result sits in an output register, so a
// stalled output only holds the block once the next result is ready.
// Reset (rst_n low, asynchronous) loads register defaults, zero age, zero
// gravity, start position and start colour of zero, and drops out_valid.
`include "particle_tick_integrator_macros.svh"

module particle_tick_integrator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pti_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pti_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pti_pkg::DT_W-1:0]            time_step,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pti_pkg::POS_W-1:0]    pos_x,
    output logic signed [pti_pkg::POS_W-1:0]    pos_y,
    output logic signed [pti_pkg::POS_W-1:0]    pos_z,
    output logic signed [pti_pkg::VEC_W-1:0]    color_r,
    output logic signed [pti_pkg::VEC_W-1:0]    color_g,
    output logic signed [pti_pkg::VEC_W-1:0]    color_b,
    output logic signed [pti_pkg::VEC_W-1:0]    color_a,
    output logic                                dead
);

    pti_pkg::cmd_t  cmd;
    pti_pkg::stat_t stat;

    pti_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    pti_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .time_step (time_step),
        .cmd       (cmd),
        .stat      (stat),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .color_r   (color_r),
        .color_g   (color_g),
        .color_b   (color_b),
        .color_a   (color_a),
        .dead      (dead)
    );

    // Checks
    `PTI_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall, "tick taken while busy")
    `PTI_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid || !out_stall, "result overwritten")
    `PTI_ASSERT_IMP(a_color_after_div, cmd.color_wr, stat.div_done, "colour update before divide")
    `PTI_ASSERT_NXT(a_dead_sticky, out_valid && dead, dead, "dead flag cleared")

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pti_pkg::*;

    localparam int     CYCLE_LIMIT = 1000000;
    localparam longint AGE_CEIL    = AGE_MAX;
    localparam longint LIFE_TOP    = 24'hffffff;

    // One result beat as the block reports it
    typedef struct {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [VEC_W-1:0] cr;
        logic signed [VEC_W-1:0] cg;
        logic signed [VEC_W-1:0] cb;
        logic signed [VEC_W-1:0] ca;
        logic                    dead;
    } tick_result_t;

    // DUT connections
    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [DT_W-1:0]         time_step;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEC_W-1:0] color_r;
    logic signed [VEC_W-1:0] color_g;
    logic signed [VEC_W-1:0] color_b;
    logic signed [VEC_W-1:0] color_a;
    logic                    dead;

    // Shadow of the register file
    logic [VEC3_W-1:0]        accel_cfg;
    logic signed [VEC_W-1:0]  glimit_cfg;
    logic [VEC_W-1:0]         speed_cfg;
    logic [VEC3_W-1:0]        dir_cfg;
    logic [LIFE_W-1:0]        life_cfg;
    logic [CFG_W-1:0]         cstep_cfg;
    logic [CFG_W-1:0]         startcol_cfg;
    logic [VEC3_W-1:0]        startpos_cfg;

    // Predicted particle state
    logic [AGE_W-1:0]         age_q;
    logic                     expired_q;
    logic signed [VEC_W-1:0]  grav_q [N_AXES];
    logic signed [POS_W-1:0]  pos_q  [N_AXES];
    logic signed [VEC_W-1:0]  col_q  [N_CHAN];

    tick_result_t pending_ticks [$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           hold_left   = 0;
    bit           no_idle     = 1'b0;

    particle_tick_integrator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .time_step (time_step),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .color_r   (color_r),
        .color_g   (color_g),
        .color_b   (color_b),
        .color_a   (color_a),
        .dead      (dead)
    );

    always #5 clk = ~clk;

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL particle_tick_integrator");
            $finish;
        end
    end

    // Signed 16-bit lane of a packed register
    function automatic longint lane16(logic [63:0] word, int i);
        logic signed [15:0] s;
        s = word[16*i +: 16];
        return s;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic int sender_gap();
        if (no_idle)
            return 0;
        if ($urandom_range(1) == 0)
            return 0;
        return pick_idle_len();
    endfunction

    // Packed lanes with a bias towards the extremes
    function automatic logic [63:0] mixed_lanes();
        logic [63:0] w;
        int          i;
        for (i = 0; i < 4; i++)
        begin
            case ($urandom_range(9))
                0:       w[16*i +: 16] = 16'h7fff;
                1:       w[16*i +: 16] = 16'h8000;
                2:       w[16*i +: 16] = 16'h0000;
                3:       w[16*i +: 16] = 16'hffff;
                default: w[16*i +: 16] = 16'($urandom);
            endcase
        end
        return w;
    endfunction

    function automatic logic [DT_W-1:0] pick_time_step();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return DT_W'($urandom_range(0, 2047));
        if (r < 92)
            return DT_W'($urandom);
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h8000;
            default: return 16'h0001;
        endcase
    endfunction

    // Advance the predicted particle by one tick and return its result beat
    function automatic tick_result_t advance_particle(logic [DT_W-1:0] dt);
        tick_result_t r;
        longint       d, a, g, sp, life, prod, p, c, q;
        int           i;
        d = dt;
        a = age_q;
        a = a + d;
        if (a > AGE_CEIL)
            a = AGE_CEIL;
        age_q = a[AGE_W-1:0];
        if (!expired_q && age_q >= life_cfg)
            expired_q = 1'b1;
        if (!expired_q)
        begin
            sp   = speed_cfg;
            life = life_cfg;
            for (i = 0; i < N_AXES; i++)
            begin
                // gravity: saturate first, then the upper clamp
                g = grav_q[i];
                g = g + ((lane16(accel_cfg, i) * d) >>> GRAV_SHIFT);
                if (g > VEC_HI)
                    g = VEC_HI;
                else if (g < VEC_LO)
                    g = VEC_LO;
                if (g > glimit_cfg)
                    g = glimit_cfg;
                grav_q[i] = g[VEC_W-1:0];
                // position
                prod = (lane16(dir_cfg, i) + g) * sp * d;
                p = pos_q[i];
                p = p + (prod >>> POS_SHIFT);
                if (p > POS_HI)
                    p = POS_HI;
                else if (p < POS_LO)
                    p = POS_LO;
                pos_q[i] = p[POS_W-1:0];
            end
            // colour fade, floor division by the lifetime
            for (i = 0; i < N_CHAN; i++)
            begin
                c = lane16(cstep_cfg, i) * d;
                if (c >= 0)
                    q = c / life;
                else
                    q = -((-c + life - 1) / life);
                p = col_q[i];
                p = p + q;
                if (p > VEC_HI)
                    p = VEC_HI;
                else if (p < VEC_LO)
                    p = VEC_LO;
                col_q[i] = p[VEC_W-1:0];
            end
        end
        r.px   = pos_q[0];
        r.py   = pos_q[1];
        r.pz   = pos_q[2];
        r.cr   = col_q[0];
        r.cg   = col_q[1];
        r.cb   = col_q[2];
        r.ca   = col_q[3];
        r.dead = expired_q;
        return r;
    endfunction

    // Register write; bits above the register's width carry junk
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        logic [63:0] mask;
        logic [63:0] data;
        int          i;
        case (idx)
            REG_GRAV_LIMIT, REG_MOVE_SPEED: mask = 64'h0000_0000_0000_ffff;
            REG_MAX_LIFE:                   mask = 64'h0000_0000_00ff_ffff;
            REG_COLOR_STEP, REG_START_COL:  mask = '1;
            default:                        mask = 64'h0000_ffff_ffff_ffff;
        endcase
        data = (val & mask) | ({$urandom, $urandom} & ~mask);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_GRAV_ACCEL: accel_cfg  = data[VEC3_W-1:0];
            REG_GRAV_LIMIT: glimit_cfg = data[VEC_W-1:0];
            REG_MOVE_SPEED: speed_cfg  = data[VEC_W-1:0];
            REG_DIRECTION:  dir_cfg    = data[VEC3_W-1:0];
            REG_MAX_LIFE:   life_cfg   = data[LIFE_W-1:0];
            REG_COLOR_STEP: cstep_cfg  = data;
            REG_START_COL:
            begin
                startcol_cfg = data;
                for (i = 0; i < N_CHAN; i++)
                    col_q[i] = data[16*i +: 16];
            end
            REG_START_POS:
            begin
                startpos_cfg = data[VEC3_W-1:0];
                for (i = 0; i < N_AXES; i++)
                    pos_q[i] = {data[16*i +: 16], 16'h0000};
            end
            default: ;
        endcase
    endtask

    // Offer one tick, wait for the beat to be taken, then maybe go idle
    task automatic send_tick(logic [DT_W-1:0] dt);
        int gap;
        @(negedge clk);
        in_valid  <= 1'b1;
        time_step <= dt;
        do
            @(posedge clk);
        while (in_stall);
        pending_ticks.push_back(advance_particle(dt));
        gap = sender_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every predicted beat has come back
    task automatic wait_results_in();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random ticks that keep the particle alive
    task automatic run_random_ticks(int count);
        logic [DT_W-1:0] dt;
        longint          a;
        int              n;
        for (n = 0; n < count; n++)
        begin
            dt = pick_time_step();
            a  = age_q;
            if (a + dt + 1 >= life_cfg)
                dt = '0;
            send_tick(dt);
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ticks.size() == 0)
            begin
                $display("%0t ns: beat with none expected, actual pos %0d %0d %0d dead %0d",
                         $time, pos_x, pos_y, pos_z, dead);
                error_count++;
            end
            else
            begin
                want = pending_ticks.pop_front();
                check_field("pos_x", want.px, pos_x);
                check_field("pos_y", want.py, pos_y);
                check_field("pos_z", want.pz, pos_z);
                check_field("color_r", want.cr, color_r);
                check_field("color_g", want.cg, color_g);
                check_field("color_b", want.cb, color_b);
                check_field("color_a", want.ca, color_a);
                check_field("dead", want.dead, dead);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
            begin
                if (stall_left == 0 && $urandom_range(3) == 0)
                    stall_left = pick_idle_len();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Reset values, then the smallest nonzero lifetime while the age is still zero
    task automatic test_reset_and_tiny_life();
        send_tick(16'h0000);
        wait_results_in();
        write_reg(REG_COLOR_STEP, 64'h8000_7fff_0123_fedc);
        write_reg(REG_MAX_LIFE, 64'd1);
        send_tick(16'h0000);
        send_tick(16'h0000);
        wait_results_in();
        write_reg(REG_MAX_LIFE, 64'd65536);
        send_tick(16'd700);
        wait_results_in();
    endtask

    // Field extremes with colour saturating both ways
    task automatic test_extreme_fields();
        write_reg(REG_MAX_LIFE, LIFE_TOP);
        write_reg(REG_MOVE_SPEED, 64'hffff);
        write_reg(REG_DIRECTION, 64'h0000_8000_7fff);
        write_reg(REG_GRAV_ACCEL, 64'h7fff_8000_0000);
        write_reg(REG_COLOR_STEP, 64'h8000_7fff_8000_7fff);
        write_reg(REG_START_COL, 64'h8000_7fff_7fff_8000);
        send_tick(16'h0000);
        send_tick(16'h0001);
        send_tick(16'hffff);
        send_tick(16'h8000);
        send_tick(16'h7fff);
        send_tick(16'h5555);
        send_tick(16'haaaa);
        wait_results_in();
    endtask

    // Position saturation at both ends, then start register reloads
    task automatic test_position_saturation();
        write_reg(REG_GRAV_ACCEL, 64'h0);
        write_reg(REG_START_POS, 64'h1234_8000_7fff);
        send_tick(16'hffff);
        send_tick(16'd1000);
        wait_results_in();
        write_reg(REG_START_POS, 64'h0000_ffff_0001);
        write_reg(REG_START_COL, 64'h1111_eeee_0000_4000);
        send_tick(16'h0000);
        wait_results_in();
    endtask

    // Gravity saturating below range and the upper clamp
    task automatic test_gravity_clamp();
        write_reg(REG_GRAV_ACCEL, 64'h4000_7fff_8000);
        write_reg(REG_GRAV_LIMIT, 64'h7fff);
        write_reg(REG_DIRECTION, 64'h0);
        write_reg(REG_MOVE_SPEED, 64'd8192);
        send_tick(16'hffff);
        send_tick(16'hffff);
        wait_results_in();
        write_reg(REG_GRAV_LIMIT, 64'h1000);
        send_tick(16'd300);
        wait_results_in();
        write_reg(REG_GRAV_LIMIT, 64'h8000);
        send_tick(16'd300);
        wait_results_in();
        write_reg(REG_GRAV_LIMIT, 64'h7fff);
        send_tick(16'd300);
        wait_results_in();
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_output_hold_off();
        int n;
        no_idle   = 1'b1;
        hold_left = 400;
        for (n = 0; n < 16; n++)
            send_tick(DT_W'($urandom_range(0, 4095)));
        wait_results_in();
        no_idle = 1'b0;
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_pause_until_drained();
        int k;
        for (k = 0; k < 3; k++)
        begin
            run_random_ticks(4);
            wait_results_in();
        end
    endtask

    // Random register settings, each followed by a burst of random ticks
    task automatic test_random_phases();
        int     phase;
        longint a, life;
        for (phase = 0; phase < 8; phase++)
        begin
            wait_results_in();
            write_reg(REG_GRAV_ACCEL, mixed_lanes());
            case (phase)
                0:       write_reg(REG_GRAV_LIMIT, 64'h7fff);
                1:       write_reg(REG_GRAV_LIMIT, 64'h8000);
                default: write_reg(REG_GRAV_LIMIT, mixed_lanes());
            endcase
            case (phase)
                0:       write_reg(REG_MOVE_SPEED, 64'hffff);
                1:       write_reg(REG_MOVE_SPEED, 64'h0);
                default: write_reg(REG_MOVE_SPEED, mixed_lanes());
            endcase
            write_reg(REG_DIRECTION, mixed_lanes());
            a    = age_q;
            life = a + $urandom_range(300000, 16777215);
            if (phase == 0 || life > LIFE_TOP)
                life = LIFE_TOP;
            write_reg(REG_MAX_LIFE, life);
            write_reg(REG_COLOR_STEP, mixed_lanes());
            if (phase < 2 || $urandom_range(1) == 0)
            begin
                write_reg(REG_START_COL, mixed_lanes());
                write_reg(REG_START_POS, mixed_lanes());
            end
            no_idle = (phase == 4);
            run_random_ticks(25);
        end
        no_idle = 1'b0;
        wait_results_in();
    endtask

    // Age reaching the limit exactly, then sticky death whatever the limit
    task automatic test_death();
        longint a;
        a = age_q;
        write_reg(REG_MAX_LIFE, a + 100);
        send_tick(16'd40);
        send_tick(16'd60);
        send_tick(16'hffff);
        wait_results_in();
        write_reg(REG_MAX_LIFE, LIFE_TOP);
        send_tick(16'd5);
        wait_results_in();
        write_reg(REG_MAX_LIFE, 64'd0);
        send_tick(16'd5);
        wait_results_in();
        // reloads still show through on a dead particle
        write_reg(REG_START_POS, mixed_lanes());
        write_reg(REG_START_COL, mixed_lanes());
        write_reg(REG_GRAV_ACCEL, mixed_lanes());
        send_tick(16'h1234);
        wait_results_in();
    endtask

    // Age runs into its ceiling and stays there
    task automatic test_age_ceiling();
        int n;
        while (age_q != AGE_MAX)
            send_tick(16'hffff);
        for (n = 0; n < 3; n++)
            send_tick(DT_W'($urandom));
        wait_results_in();
    endtask

    initial
    begin : main
        int i;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_GRAV_ACCEL;
        cfg_data  = '0;
        in_valid  = 1'b0;
        time_step = '0;
        // predictor reset state
        accel_cfg    = '0;
        glimit_cfg   = 16'sh7fff;
        speed_cfg    = 16'd8192;
        dir_cfg      = '0;
        life_cfg     = 24'd65536;
        cstep_cfg    = '0;
        startcol_cfg = '0;
        startpos_cfg = '0;
        age_q        = '0;
        expired_q    = 1'b0;
        for (i = 0; i < N_AXES; i++)
        begin
            grav_q[i] = '0;
            pos_q[i]  = '0;
        end
        for (i = 0; i < N_CHAN; i++)
            col_q[i] = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_and_tiny_life();
        test_extreme_fields();
        test_position_saturation();
        test_gravity_clamp();
        test_output_hold_off();
        test_pause_until_drained();
        test_random_phases();
        test_death();
        test_age_ceiling();

        wait_results_in();
        repeat (60) @(posedge clk);
        if (error_count == 0 && pending_ticks.size() == 0)
            $display("PASS particle_tick_integrator");
        else
            $display("FAIL particle_tick_integrator");
        $finish;
    end

endmodule
